// File: rtl/percentile_contrast_stretch_defines.svh
// Assertion macros used by the contrast stretch datapath.
`ifndef PERCENTILE_CONTRAST_STRETCH_DEFINES_SVH
`define PERCENTILE_CONTRAST_STRETCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define PCS_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);
`else
`define PCS_ASSERT(label, prop, msg)
`define PCS_ASSERT_NEXT(label, trig, prop, msg)
`endif
`endif

// File: rtl/pcs_pkg.sv
package pcs_pkg;

   localparam int LEVEL_BITS  = 8;
   localparam int LOW_BITS    = 16;
   localparam int HIGH_BITS   = 17;
   localparam int PIXEL_FIELD = 16;

   // floor(x / 100) = (x * RECIP_MUL) >> RECIP_SHIFT, exact for x below 199728
   localparam int RANK_X_BITS = 17;
   localparam int RECIP_BITS  = 18;
   localparam int RECIP_SHIFT = 24;
   localparam int MUL_BITS    = RANK_X_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0]  RECIP_MUL  = 18'd167773;
   localparam logic [RANK_X_BITS-1:0] RANK_ROUND = 17'd99;

   // (v - low) * 255 fits 24 bits; span << 7 fits 24 bits
   localparam int NUM_BITS  = 24;
   localparam int DIV_SHIFT = LEVEL_BITS - 1;
   localparam int DIV_CNT_BITS = $clog2(LEVEL_BITS);

   localparam logic ACTION_COLLECT = 1'b0;
   localparam logic ACTION_MAP     = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COL_WR,
      ST_RANK_LO,
      ST_RANK_HI,
      ST_WALK,
      ST_WALK_END,
      ST_LEVELS,
      ST_MAP_PREP,
      ST_MAP_DIV,
      ST_MAP_DONE
   } pcs_state_type;

   typedef struct packed {
      logic take;
      logic cnt_inc;
      logic cnt_clr;
      logic hist_inc;
      logic clear;
      logic walk;
      logic walk_init;
      logic mul_en;
      logic mul_round;
      logic rank_lo_ld;
      logic rank_hi_ld;
      logic levels_ld;
      logic map_prep;
      logic div_step;
      logic rsp_load;
   } pcs_cmd_type;

   typedef struct packed {
      logic cnt_full;
      logic item_last;
      logic sweep_end;
      logic div_last;
      logic rsp_free;
   } pcs_status_type;

endpackage

// File: rtl/percentile_contrast_stretch.sv
// Collect pixel: ST_COL_WR increments the bin before the next transfer is taken; no result.
// Last collect pixel adds a histogram walk over every bin (one bin per cycle).
// Map pixel: req_ready low through MAP_PREP, the 8-step shift-subtract divider and MAP_DONE,
// which loads the result once rsp is free. A waiting result does not block the next transfer.
// Reset: synchronous; then a clearing sweep over all 2^PIXEL_BITS bins (65536 by default)
// over the histogram memory with req_ready low. Levels reset to low 0, high 1.
module percentile_contrast_stretch
   import pcs_pkg::*;
#(
   parameter int PIXEL_BITS = 16,
   parameter int MAX_PIXELS = 8192
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   input  logic [PIXEL_FIELD-1:0] req_pixel,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [LEVEL_BITS-1:0]  rsp_level,
   output logic [LOW_BITS-1:0]    rsp_low_level,
   output logic [HIGH_BITS-1:0]   rsp_high_level
);

   pcs_cmd_type    cmd;
   pcs_status_type status;

   pcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_last   (req_last),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   pcs_datapath #(
      .PIXEL_BITS (PIXEL_BITS),
      .MAX_PIXELS (MAX_PIXELS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_pixel      (req_pixel),
      .req_last       (req_last),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_level      (rsp_level),
      .rsp_low_level  (rsp_low_level),
      .rsp_high_level (rsp_high_level),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

// File: rtl/pcs_ctrl.sv
module pcs_ctrl
   import pcs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_action,
   input  logic           req_last,
   output logic           req_ready,
   input  pcs_status_type status,
   output pcs_cmd_type    cmd
);

   pcs_state_type state_ff;
   pcs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.sweep_end) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACTION_COLLECT) begin
                  if (!status.cnt_full) begin
                     state_in = ST_COL_WR;
                  end else if (req_last) begin
                     state_in = ST_RANK_LO;
                  end
               end else if (!status.cnt_full) begin
                  state_in = ST_MAP_PREP;
               end
            end
         end
         ST_COL_WR: begin
            state_in = status.item_last ? ST_RANK_LO : ST_IDLE;
         end
         ST_RANK_LO:  state_in = ST_RANK_HI;
         ST_RANK_HI:  state_in = ST_WALK;
         ST_WALK: begin
            if (status.sweep_end) state_in = ST_WALK_END;
         end
         ST_WALK_END: state_in = ST_LEVELS;
         ST_LEVELS:   state_in = ST_IDLE;
         ST_MAP_PREP: state_in = ST_MAP_DIV;
         ST_MAP_DIV: begin
            if (status.div_last) state_in = ST_MAP_DONE;
         end
         ST_MAP_DONE: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.take    = req_valid;
            cmd.cnt_inc = req_valid && !status.cnt_full;
            cmd.cnt_clr = req_valid && (req_action == ACTION_MAP) && req_last;
         end
         ST_COL_WR: cmd.hist_inc = 1'b1;
         ST_RANK_LO: cmd.mul_en = 1'b1;
         ST_RANK_HI: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_round  = 1'b1;
            cmd.rank_lo_ld = 1'b1;
            cmd.walk_init  = 1'b1;
         end
         ST_WALK: begin
            cmd.walk       = 1'b1;
            cmd.rank_hi_ld = 1'b1;
         end
         ST_WALK_END: cmd = '0;
         ST_LEVELS: begin
            cmd.levels_ld = 1'b1;
            cmd.cnt_clr   = 1'b1;
         end
         ST_MAP_PREP: cmd.map_prep = 1'b1;
         ST_MAP_DIV:  cmd.div_step = 1'b1;
         ST_MAP_DONE: cmd.rsp_load = status.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

// File: rtl/pcs_datapath.sv
`include "percentile_contrast_stretch_defines.svh"

module pcs_datapath
   import pcs_pkg::*;
#(
   parameter int PIXEL_BITS = 16,
   parameter int MAX_PIXELS = 8192
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [PIXEL_FIELD-1:0] req_pixel,
   input  logic                   req_last,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [LEVEL_BITS-1:0]  rsp_level,
   output logic [LOW_BITS-1:0]    rsp_low_level,
   output logic [HIGH_BITS-1:0]   rsp_high_level,
   input  pcs_cmd_type            cmd,
   output pcs_status_type         status
);

   localparam int BINS     = 2 ** PIXEL_BITS;
   localparam int CNT_BITS = $clog2(MAX_PIXELS + 1);
   localparam int CMP_BITS = NUM_BITS + 1;

   logic [CNT_BITS-1:0]   hist_mem [BINS];
   logic [CNT_BITS-1:0]   rd_data_ff;
   logic [PIXEL_BITS-1:0] rd_addr;
   logic [PIXEL_BITS-1:0] wr_addr;
   logic [CNT_BITS-1:0]   wr_data;
   logic [CNT_BITS-1:0]   bin_inc;
   logic                  hist_we;

   logic [PIXEL_BITS-1:0] pix_ff;
   logic                  last_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [PIXEL_BITS-1:0] walk_addr_ff;
   logic                  walk_vld_ff;
   logic [PIXEL_BITS-1:0] walk_tag_ff;

   logic [MUL_BITS-1:0]    mul_ff;
   logic [RANK_X_BITS-1:0] mul_x;
   logic [MUL_BITS-1:0]    quot_full;
   logic [CNT_BITS-1:0]    rank_lo_ff;
   logic [CNT_BITS-1:0]    rank_hi_ff;

   logic [CNT_BITS-1:0]   cum_ff;
   logic [CNT_BITS:0]     cum_sum;
   logic [CNT_BITS-1:0]   cum_in;
   logic                  got_lo_ff;
   logic                  got_hi_ff;
   logic [PIXEL_BITS-1:0] lo_found_ff;
   logic [PIXEL_BITS-1:0] hi_found_ff;

   logic [LOW_BITS-1:0]  low_ff;
   logic [HIGH_BITS-1:0] high_ff;
   logic [LOW_BITS-1:0]  low_in;
   logic [HIGH_BITS-1:0] high_in;

   logic [HIGH_BITS-1:0]    low_ext;
   logic [HIGH_BITS-1:0]    pix_ext;
   logic [HIGH_BITS-1:0]    clamp_val;
   logic [HIGH_BITS-1:0]    diff;
   logic [NUM_BITS-1:0]     num_in;
   logic [NUM_BITS-1:0]     den_in;
   logic [NUM_BITS-1:0]     rem_ff;
   logic [NUM_BITS-1:0]     den_ff;
   logic [LEVEL_BITS-1:0]   quot_ff;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff;

   logic                  rsp_valid_ff;
   logic [LEVEL_BITS-1:0] rsp_level_ff;
   logic [LOW_BITS-1:0]   rsp_low_ff;
   logic [HIGH_BITS-1:0]  rsp_high_ff;

   // histogram: read-first, separate read and write ports, registered read
   // hold a full bin: its count already exceeds any rank
   assign bin_inc = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 1'b1;
   assign rd_addr = (cmd.walk || cmd.clear) ? walk_addr_ff : req_pixel[PIXEL_BITS-1:0];
   assign wr_addr = (cmd.walk || cmd.clear) ? walk_addr_ff : pix_ff;
   assign wr_data = (cmd.walk || cmd.clear) ? '0 : bin_inc;
   assign hist_we = cmd.walk || cmd.clear || cmd.hist_inc;

   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[rd_addr];
      if (hist_we) begin
         hist_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pix_ff  <= req_pixel[PIXEL_BITS-1:0];
         last_ff <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_clr) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // sweep address wraps back to zero after each full pass
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_addr_ff <= '0;
         walk_vld_ff  <= 1'b0;
      end else begin
         walk_vld_ff <= cmd.walk;
         if (cmd.walk || cmd.clear) begin
            walk_addr_ff <= walk_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      walk_tag_ff <= walk_addr_ff;
   end

   // ranks: floor(n/100) and n - ceil(n/100)
   assign mul_x     = cmd.mul_round ? RANK_X_BITS'(cnt_ff) + RANK_ROUND : RANK_X_BITS'(cnt_ff);
   assign quot_full = mul_ff >> RECIP_SHIFT;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         mul_ff <= MUL_BITS'(mul_x) * MUL_BITS'(RECIP_MUL);
      end
      if (cmd.rank_lo_ld) begin
         rank_lo_ff <= quot_full[CNT_BITS-1:0];
      end
      if (cmd.rank_hi_ld) begin
         rank_hi_ff <= cnt_ff - quot_full[CNT_BITS-1:0];
      end
   end

   // saturate the running sum; a full sum is above any rank
   assign cum_sum = {1'b0, cum_ff} + {1'b0, rd_data_ff};
   assign cum_in  = cum_sum[CNT_BITS] ? '1 : cum_sum[CNT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cum_ff    <= '0;
         got_lo_ff <= 1'b0;
         got_hi_ff <= 1'b0;
      end else if (cmd.walk_init) begin
         cum_ff    <= '0;
         got_lo_ff <= 1'b0;
         got_hi_ff <= 1'b0;
      end else if (walk_vld_ff) begin
         cum_ff <= cum_in;
         if (!got_lo_ff && (cum_in > rank_lo_ff)) begin
            got_lo_ff <= 1'b1;
         end
         if (!got_hi_ff && (cum_in > rank_hi_ff)) begin
            got_hi_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         lo_found_ff <= '0;
         hi_found_ff <= '0;
      end else if (walk_vld_ff) begin
         if (!got_lo_ff && (cum_in > rank_lo_ff)) begin
            lo_found_ff <= walk_tag_ff;
         end
         if (!got_hi_ff && (cum_in > rank_hi_ff)) begin
            hi_found_ff <= walk_tag_ff;
         end
      end
   end

   // force high above low
   always_comb begin
      low_in  = LOW_BITS'(lo_found_ff);
      high_in = HIGH_BITS'(hi_found_ff);
      if (high_in <= HIGH_BITS'(low_in)) begin
         high_in = HIGH_BITS'(low_in) + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= HIGH_BITS'(1);
      end else if (cmd.levels_ld) begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   // map: clamp, scale by 255, then one quotient bit per cycle
   assign low_ext = HIGH_BITS'(low_ff);
   assign pix_ext = HIGH_BITS'(pix_ff);

   always_comb begin
      clamp_val = pix_ext;
      if (pix_ext < low_ext) begin
         clamp_val = low_ext;
      end else if (pix_ext > high_ff) begin
         clamp_val = high_ff;
      end
   end

   assign diff   = clamp_val - low_ext;
   assign num_in = (NUM_BITS'(diff) << LEVEL_BITS) - NUM_BITS'(diff);
   assign den_in = NUM_BITS'(high_ff - low_ext) << DIV_SHIFT;

   always_ff @(posedge clock) begin
      if (cmd.map_prep) begin
         rem_ff     <= num_in;
         den_ff     <= den_in;
         quot_ff    <= '0;
         div_cnt_ff <= DIV_CNT_BITS'(DIV_SHIFT);
      end else if (cmd.div_step) begin
         if (rem_ff >= den_ff) begin
            rem_ff  <= rem_ff - den_ff;
            quot_ff <= {quot_ff[LEVEL_BITS-2:0], 1'b1};
         end else begin
            quot_ff <= {quot_ff[LEVEL_BITS-2:0], 1'b0};
         end
         den_ff     <= den_ff >> 1;
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_level_ff <= quot_ff;
         rsp_low_ff   <= low_ff;
         rsp_high_ff  <= high_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_level      = rsp_level_ff;
   assign rsp_low_level  = rsp_low_ff;
   assign rsp_high_level = rsp_high_ff;

   assign status.cnt_full  = (cnt_ff == CNT_BITS'(MAX_PIXELS));
   assign status.item_last = last_ff;
   assign status.sweep_end = (walk_addr_ff == '1);
   assign status.div_last  = (div_cnt_ff == '0);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   `PCS_ASSERT(a_level_order, high_ff > low_ext, "high level not above low level")
   `PCS_ASSERT(a_cnt_bound, cnt_ff <= CNT_BITS'(MAX_PIXELS), "pixel count beyond limit")
   `PCS_ASSERT(a_div_range, cmd.div_step |-> (CMP_BITS'(rem_ff) < (CMP_BITS'(den_ff) << 1)), "quotient bit overflow")
   `PCS_ASSERT_NEXT(a_cnt_cleared, cmd.levels_ld, cnt_ff == '0, "count not cleared after levels")

endmodule
